@@ design/adsr_pkg.sv @@
`default_nettype none

package adsr_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned GAIN_W   = 17;
    localparam int unsigned FRAMES_W = 24;
    localparam int unsigned POS_W    = 26;
    localparam int unsigned CHAN_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Shared multiplier: gain-sized operand times frame-sized operand
    localparam int unsigned PROD_W = GAIN_W + FRAMES_W;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;
    localparam logic [POS_W-1:0]  POS_MAX    = 26'h3FF_FFFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 3'd5;

    typedef struct packed {
        logic                       note_start;
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] scaled_0;
        logic signed [SAMPLE_W-1:0] scaled_1;
        logic [GAIN_W-1:0]          gain;
    } out_item_t;

    typedef struct packed {
        logic [FRAMES_W-1:0] attack_frames;
        logic [FRAMES_W-1:0] decay_frames;
        logic [GAIN_W-1:0]   sustain_level;
        logic [FRAMES_W-1:0] release_frames;
        logic [FRAMES_W-1:0] note_frames;
        logic [CHAN_W-1:0]   channel_count;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_HOLD,
        S_REND,
        S_PICK,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SCALE0,
        S_SCALE1,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_ATTACK,
        PH_DECAY,
        PH_RELEASE,
        PH_FLAT
    } phase_t;

endpackage

`default_nettype wire

@@ design/adsr_cfg.sv @@
`default_nettype none

module adsr_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]    index,
    input  wire logic [adsr_pkg::CFG_DATA_W-1:0]   data,
    output adsr_pkg::cfg_t                         cfg
);
    import adsr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_ATTACK:  cfg_next.attack_frames  = data;
                REG_DECAY:   cfg_next.decay_frames   = data;
                REG_SUSTAIN: cfg_next.sustain_level  = data[GAIN_W-1:0];
                REG_RELEASE: cfg_next.release_frames = data;
                REG_NOTE:    cfg_next.note_frames    = data;
                REG_CHANNEL: cfg_next.channel_count  = data[CHAN_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_frames  <= '0;
            cfg_reg.decay_frames   <= '0;
            cfg_reg.sustain_level  <= UNITY_GAIN;
            cfg_reg.release_frames <= '0;
            cfg_reg.note_frames    <= '0;
            cfg_reg.channel_count  <= 2'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/adsr_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in GAIN_W bits and that the divisor is non-zero.
module adsr_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [adsr_pkg::PROD_W-1:0]     numer,
    input  wire logic [adsr_pkg::FRAMES_W-1:0]   denom,
    output logic                                 done,
    output logic [adsr_pkg::GAIN_W-1:0]          quot
);
    import adsr_pkg::*;

    localparam int unsigned CNT_W = $clog2(GAIN_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [FRAMES_W-1:0] rem_reg, rem_next;
    logic [GAIN_W-1:0]   lo_reg, lo_next;
    logic [GAIN_W-1:0]   quot_reg, quot_next;
    logic [FRAMES_W-1:0] den_reg, den_next;
    logic [FRAMES_W:0]   trial;
    logic                fits;

    // One trial subtraction per cycle
    assign trial = {rem_reg, lo_reg[GAIN_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(GAIN_W);
            rem_next  = numer[PROD_W-1:GAIN_W];
            lo_next   = numer[GAIN_W-1:0];
            quot_next = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? FRAMES_W'(trial - {1'b0, den_reg}) : trial[FRAMES_W-1:0];
            lo_next   = {lo_reg[GAIN_W-2:0], 1'b0};
            quot_next = {quot_reg[GAIN_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

@@ design/adsr_envelope_gain_top.sv @@
`default_nettype none

// Channel  Direction  Handshake          Payload
// in       to block   in_valid/in_stall  in_data   (note_start, sample_0, sample_1)
// out      from block out_valid/out_stall out_data (scaled_0, scaled_1, gain)
// cfg      to block   cfg_wr_en          cfg_index, cfg_data
//
// A frame runs through the states SUM, HOLD, REND and PICK, then MUL, DIV_GO and DIV_WAIT when its gain
// needs a division by the serial divider (attack, decay, release), then SCALE0, SCALE1 and DONE.
// One frame at a time: in_stall is high from transfer until the result is registered.
// The output register lets the next frame be taken while a result waits on out_stall.
// Reset clears the frame position and out_valid, and returns the registers to their defaults.
module adsr_envelope_gain_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire adsr_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output adsr_pkg::out_item_t                    out_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import adsr_pkg::*;

    cfg_t cfg;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    t_reg, t_next;
    in_item_t            in_reg, in_next;
    logic [FRAMES_W:0]   ad_reg, ad_next;
    logic [FRAMES_W:0]   hold_end_reg, hold_end_next;
    logic [POS_W-1:0]    rel_end_reg, rel_end_next;
    logic [GAIN_W-1:0]   coef_reg, coef_next;
    logic [FRAMES_W-1:0] x_reg, x_next;
    logic [FRAMES_W-1:0] den_reg, den_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SAMPLE_W-1:0] scaled0_reg, scaled0_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    logic                accept;
    logic                out_free;
    logic [POS_W-1:0]    t_start;
    logic [GAIN_W-1:0]   sus_clamp;
    logic [GAIN_W-1:0]   mul_a;
    logic [FRAMES_W-1:0] mul_b;
    logic [SAMPLE_W-1:0] mag0, mag1;
    logic [SAMPLE_W-1:0] prod_mag;
    logic                div_start;
    logic                div_done;
    logic [GAIN_W-1:0]   div_quot;

    adsr_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    adsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (prod_reg),
        .denom (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign t_start   = in_data.note_start ? '0 : pos_reg;
    assign sus_clamp = (cfg.sustain_level > UNITY_GAIN) ? UNITY_GAIN : cfg.sustain_level;
    assign div_start = (state_reg == S_DIV_GO);

    // Sample magnitudes; the most negative sample maps to 32768
    assign mag0 = in_reg.sample_0[SAMPLE_W-1] ? SAMPLE_W'(-in_reg.sample_0) : in_reg.sample_0;
    assign mag1 = in_reg.sample_1[SAMPLE_W-1] ? SAMPLE_W'(-in_reg.sample_1) : in_reg.sample_1;
    assign prod_mag = prod_reg[SAMPLE_W+15:16];

    // Shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_SCALE0:
            begin
                mul_a = gain_reg;
                mul_b = FRAMES_W'(mag0);
            end
            S_SCALE1:
            begin
                mul_a = gain_reg;
                mul_b = FRAMES_W'(mag1);
            end
            default:
            begin
                mul_a = coef_reg;
                mul_b = x_reg;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        t_next         = t_reg;
        in_next        = in_reg;
        ad_next        = ad_reg;
        hold_end_next  = hold_end_reg;
        rel_end_next   = rel_end_reg;
        coef_next      = coef_reg;
        x_next         = x_reg;
        den_next       = den_reg;
        gain_next      = gain_reg;
        prod_next      = prod_reg;
        scaled0_next   = scaled0_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    in_next    = in_data;
                    t_next     = t_start;
                    pos_next   = (t_start != POS_MAX) ? t_start + 1'b1 : t_start;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                ad_next    = {1'b0, cfg.attack_frames} + {1'b0, cfg.decay_frames};
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                hold_end_next = ({1'b0, cfg.note_frames} > ad_reg) ?
                                {1'b0, cfg.note_frames} : ad_reg;
                state_next    = S_REND;
            end
            S_REND:
            begin
                rel_end_next = POS_W'(hold_end_reg) + POS_W'(cfg.release_frames);
                state_next   = S_PICK;
            end
            S_PICK:
            begin
                den_next = cfg.release_frames;
                if (t_reg < POS_W'(cfg.attack_frames))
                begin
                    phase_next = PH_ATTACK;
                    coef_next  = UNITY_GAIN;
                    x_next     = t_reg[FRAMES_W-1:0];
                    den_next   = cfg.attack_frames;
                    state_next = S_MUL;
                end
                else if (t_reg < POS_W'(ad_reg))
                begin
                    phase_next = PH_DECAY;
                    coef_next  = UNITY_GAIN - sus_clamp;
                    x_next     = FRAMES_W'(t_reg - POS_W'(cfg.attack_frames));
                    den_next   = cfg.decay_frames;
                    state_next = S_MUL;
                end
                else if (t_reg < POS_W'(hold_end_reg))
                begin
                    phase_next = PH_FLAT;
                    gain_next  = sus_clamp;
                    state_next = S_SCALE0;
                end
                else if (t_reg < rel_end_reg)
                begin
                    phase_next = PH_RELEASE;
                    coef_next  = sus_clamp;
                    x_next     = FRAMES_W'(rel_end_reg - t_reg);
                    state_next = S_MUL;
                end
                else
                begin
                    phase_next = PH_FLAT;
                    gain_next  = '0;
                    state_next = S_SCALE0;
                end
            end
            S_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    gain_next  = (phase_reg == PH_DECAY) ? GAIN_W'(UNITY_GAIN - div_quot)
                                                         : div_quot;
                    state_next = S_SCALE0;
                end
            end
            S_SCALE0:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_SCALE1;
            end
            S_SCALE1:
            begin
                scaled0_next = in_reg.sample_0[SAMPLE_W-1] ? SAMPLE_W'(-prod_mag) : prod_mag;
                prod_next    = mul_a * mul_b;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_next.scaled_0 = scaled0_reg;
                    if (cfg.channel_count[1])
                    begin
                        out_next.scaled_1 = in_reg.sample_1[SAMPLE_W-1] ?
                                            SAMPLE_W'(-prod_mag) : prod_mag;
                    end
                    else
                    begin
                        out_next.scaled_1 = '0;
                    end
                    out_next.gain  = gain_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg    <= phase_next;
        t_reg        <= t_next;
        in_reg       <= in_next;
        ad_reg       <= ad_next;
        hold_end_reg <= hold_end_next;
        rel_end_reg  <= rel_end_next;
        coef_reg     <= coef_next;
        x_reg        <= x_next;
        den_reg      <= den_next;
        gain_reg     <= gain_next;
        prod_reg     <= prod_next;
        scaled0_reg  <= scaled0_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

@@ dv/adsr_gain_checker.sv @@
`timescale 1ns / 100ps

// Watches the frame, result and register ports of the envelope block. It keeps its own
// copy of the registers and of the frame position, works out the result of every frame
// transfer, and compares each result transfer with the oldest outstanding prediction.
module adsr_gain_checker
    import adsr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire in_item_t              in_data,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire out_item_t             out_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fault_count,
    output int                         frames_in_flight
);

    // Shadow registers and envelope position
    logic [FRAMES_W-1:0] attack_len;
    logic [FRAMES_W-1:0] decay_len;
    logic [GAIN_W-1:0]   sustain_gain;
    logic [FRAMES_W-1:0] release_len;
    logic [FRAMES_W-1:0] note_len;
    logic [CHAN_W-1:0]   chan_sel;
    logic [POS_W-1:0]    frame_pos;

    out_item_t expected_frames[$];
    out_item_t predicted;
    out_item_t oldest;
    logic [GAIN_W-1:0] frame_gain;
    int fail_tally;

    // Piecewise linear gain at a given frame position, Q1.16
    function automatic logic [GAIN_W-1:0] envelope_at(input logic [POS_W-1:0] pos);
        longint unsigned t;
        longint unsigned a;
        longint unsigned d;
        longint unsigned r;
        longint unsigned n;
        longint unsigned s;
        longint unsigned unity;
        longint unsigned hold;
        longint unsigned w;
        t = pos;
        a = attack_len;
        d = decay_len;
        r = release_len;
        n = note_len;
        unity = UNITY_GAIN;
        // sustain above unity is clipped to unity
        s = (sustain_gain > UNITY_GAIN) ? unity : sustain_gain;
        if (t < a)
            return GAIN_W'((t * unity) / a);
        t = t - a;
        if (t < d)
            return GAIN_W'(unity - ((unity - s) * t) / d);
        t = t - d;
        // a note shorter than attack plus decay has no hold at all
        hold = (n > a + d) ? n - a - d : 0;
        if (t < hold)
            return GAIN_W'(s);
        w = t - hold;
        if (r == 0 || w >= r)
            return '0;
        return GAIN_W'((s * (r - w)) / r);
    endfunction

    // Sample times gain, magnitude truncated so the result rounds toward zero
    function automatic logic signed [SAMPLE_W-1:0] apply_gain(
        input logic signed [SAMPLE_W-1:0] x,
        input logic [GAIN_W-1:0]          g
    );
        longint mag;
        mag = (x < 0) ? -longint'(x) : longint'(x);
        mag = (mag * longint'(g)) / 65536;
        return SAMPLE_W'((x < 0) ? -mag : mag);
    endfunction

    task automatic flag_mismatch(input string field, input int want, input int got);
        fail_tally++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len   = '0;
            decay_len    = '0;
            sustain_gain = UNITY_GAIN;
            release_len  = '0;
            note_len     = '0;
            chan_sel     = 2'd1;
            frame_pos    = '0;
            fail_tally   = 0;
            expected_frames.delete();
            fault_count      <= 0;
            frames_in_flight <= 0;
        end
        else
        begin
            // register writes, masked to each register's width
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ATTACK:  attack_len   = cfg_data[FRAMES_W-1:0];
                    REG_DECAY:   decay_len    = cfg_data[FRAMES_W-1:0];
                    REG_SUSTAIN: sustain_gain = cfg_data[GAIN_W-1:0];
                    REG_RELEASE: release_len  = cfg_data[FRAMES_W-1:0];
                    REG_NOTE:    note_len     = cfg_data[FRAMES_W-1:0];
                    REG_CHANNEL: chan_sel     = cfg_data[CHAN_W-1:0];
                    default:     ;
                endcase
            end

            // frame transfer: predict its result, then advance the position
            if (in_valid && !in_stall)
            begin
                if (in_data.note_start)
                    frame_pos = '0;
                frame_gain = envelope_at(frame_pos);
                predicted.scaled_0 = apply_gain(in_data.sample_0, frame_gain);
                // channel count 0 behaves as one channel, 3 as two
                predicted.scaled_1 = (chan_sel >= 2'd2)
                                   ? apply_gain(in_data.sample_1, frame_gain) : '0;
                predicted.gain = frame_gain;
                expected_frames.push_back(predicted);
                if (frame_pos < POS_MAX)
                    frame_pos++;
            end

            // result transfer: compare with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    fail_tally++;
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, out_data);
                end
                else
                begin
                    oldest = expected_frames.pop_front();
                    if (out_data.scaled_0 !== oldest.scaled_0)
                        flag_mismatch("scaled_0", int'(oldest.scaled_0),
                                      int'(out_data.scaled_0));
                    if (out_data.scaled_1 !== oldest.scaled_1)
                        flag_mismatch("scaled_1", int'(oldest.scaled_1),
                                      int'(out_data.scaled_1));
                    if (out_data.gain !== oldest.gain)
                        flag_mismatch("gain", int'(oldest.gain), int'(out_data.gain));
                end
            end

            fault_count      <= fail_tally;
            frames_in_flight <= expected_frames.size();
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

// Drives audio frames and register settings into the envelope block with random gaps
// and result stalls; the checker beside the block predicts and compares.
module tb;
    import adsr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int FRAME_TARGET  = 1900;
    localparam int PHASE_FRAMES  = 150;
    localparam int SETTLE_CYCLES = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ATTACK;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fault_count;
    int frames_in_flight;
    int cycle_count = 0;
    int frames_sent = 0;
    bit calm        = 1'b0;

    adsr_envelope_gain_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    adsr_gain_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fault_count      (fault_count),
        .frames_in_flight (frames_in_flight)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: a fresh stall length for every result
    initial
    begin
        int hold_off;
        forever
        begin
            hold_off = calm ? 0 : $urandom_range(0, 10);
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // One frame transfer after a random gap; valid stays up until the next call
    task automatic send_frame(
        input logic                       start,
        input logic signed [SAMPLE_W-1:0] s0,
        input logic signed [SAMPLE_W-1:0] s1
    );
        int gap;
        in_item_t frame;
        gap = calm ? 0 : $urandom_range(0, 10);
        frame.note_start = start;
        frame.sample_0   = s0;
        frame.sample_1   = s1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= frame;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        frames_sent++;
    endtask

    // Drop valid and wait until every result is back and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_in_flight != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    // Full register update, only once the block is idle
    task automatic program_regs(
        input logic [CFG_DATA_W-1:0] a,
        input logic [CFG_DATA_W-1:0] d,
        input logic [CFG_DATA_W-1:0] s,
        input logic [CFG_DATA_W-1:0] r,
        input logic [CFG_DATA_W-1:0] n,
        input logic [CFG_DATA_W-1:0] c
    );
        settle();
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_SUSTAIN, s);
        write_reg(REG_RELEASE, r);
        write_reg(REG_NOTE, n);
        write_reg(REG_CHANNEL, c);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly short envelope segments so every phase is reached, now and then the extremes
    function automatic logic [CFG_DATA_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 24'hFF_FFFF;
            1:       return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(0, 12));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       return -16'sd32768;
                1:       return 16'sd32767;
                2:       return -16'sd1;
                3:       return 16'sd1;
                default: return 16'sd0;
            endcase
        end
        return SAMPLE_W'($urandom());
    endfunction

    // A note: starts with note_start, now and then a stray restart inside it
    task automatic play_note(input int len);
        for (int i = 0; i < len; i++)
            send_frame(i == 0 || $urandom_range(0, 39) == 0, pick_sample(), pick_sample());
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] a;
        logic [CFG_DATA_W-1:0] d;
        logic [CFG_DATA_W-1:0] s;
        logic [CFG_DATA_W-1:0] r;
        logic [CFG_DATA_W-1:0] n;
        logic [CFG_DATA_W-1:0] c;
        longint reach;
        int phase_base;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no attack, decay, note or release, so the gain is zero
        send_frame(1'b0, 16'sd32767, -16'sd32768);
        send_frame(1'b1, -16'sd32768, 16'sd32767);
        send_frame(1'b0, -16'sd1, 16'sd1);

        // Zero attack and decay: unity at once, then zero release cuts to silence
        program_regs(24'd0, 24'd0, 24'd65536, 24'd0, 24'd4, 24'd2);
        send_frame(1'b1, 16'sd32767, -16'sd32768);
        send_frame(1'b0, -16'sd32768, 16'sd32767);
        send_frame(1'b0, -16'sd1, 16'sd1);
        send_frame(1'b0, 16'sd0, -16'sd1);
        send_frame(1'b0, 16'sd12345, -16'sd23456);
        send_frame(1'b0, -16'sd32768, -16'sd32768);

        // Note shorter than attack plus decay, three channels acting as two
        program_regs(24'd3, 24'd2, 24'd30000, 24'd3, 24'd2, 24'd3);
        send_frame(1'b1, -16'sd32768, 16'sd32767);
        for (int i = 0; i < 8; i++)
            send_frame(1'b0, (i % 2) ? -16'sd32768 : 16'sd32767, pick_sample());
        send_frame(1'b1, -16'sd32767, 16'sd32767);

        // Sustain above unity with zero channels acting as one
        program_regs(24'd0, 24'd2, 24'h01_FFFF, 24'd2, 24'd3, 24'd0);
        send_frame(1'b1, 16'sd32767, -16'sd32768);
        send_frame(1'b0, -16'sd32768, 16'sd32767);
        send_frame(1'b0, 16'sd32767, -16'sd1);
        send_frame(1'b0, -16'sd32768, 16'sd1);
        send_frame(1'b0, 16'sd1, 16'sd32767);

        // Random phases, each with fresh settings and a run of notes
        for (int phase = 0; frames_sent < FRAME_TARGET; phase++)
        begin
            if (phase == 0)
            begin
                a = 24'hFF_FFFF; d = 24'hFF_FFFF; s = 24'hFF_FFFF;
                r = 24'hFF_FFFF; n = 24'hFF_FFFF; c = 24'hFF_FFFF;
            end
            else if (phase == 1)
            begin
                a = '0; d = '0; s = '0; r = '0; n = '0; c = '0;
            end
            else
            begin
                a = pick_length();
                d = pick_length();
                r = pick_length();
                n = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 30) : pick_length());
                case ($urandom_range(0, 4))
                    0:       s[GAIN_W-1:0] = '0;
                    1:       s[GAIN_W-1:0] = UNITY_GAIN;
                    2:       s[GAIN_W-1:0] = GAIN_W'($urandom_range(65537, 131071));
                    default: s[GAIN_W-1:0] = GAIN_W'($urandom_range(0, 65536));
                endcase
                // upper bits beyond the register width are ignored by the block
                s[CFG_DATA_W-1:GAIN_W] = ($urandom_range(0, 3) == 0)
                                       ? (CFG_DATA_W-GAIN_W)'($urandom()) : '0;
                c = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
                c[CHAN_W-1:0] = CHAN_W'($urandom_range(0, 3));
            end
            program_regs(a, d, s, r, n, c);
            calm = ($urandom_range(0, 3) == 0);

            // note lengths up to just past the end of the release, with the reach capped at 60
            reach = ((longint'(a) + d > n) ? longint'(a) + d : longint'(n)) + r;
            if (reach > 60)
                reach = 60;
            phase_base = frames_sent;
            while (frames_sent - phase_base < PHASE_FRAMES && frames_sent < FRAME_TARGET)
                play_note($urandom_range(1, int'(reach) + 6));
        end

        // Drain and give the verdict
        settle();
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ adsr_envelope_gain_top.f @@
design/adsr_pkg.sv
design/adsr_cfg.sv
design/adsr_div.sv
design/adsr_envelope_gain_top.sv
dv/adsr_gain_checker.sv
dv/tb.sv
